// ----- hw/rtl/ctdc_pkg.sv -----
`default_nettype none
package ctdc_pkg;

  localparam int TABLE_DEPTH = 128;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int KIND_W      = 2;
  localparam int RAW_W       = 10;
  localparam int EIDX_W      = 7;
  localparam int VAL_W       = 16;
  localparam int DIST_W      = 10;
  localparam int NIDX_W      = 7;
  localparam int STEP_W      = $clog2(VAL_W);
  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_DATA_W  = 32;

  localparam logic [VAL_W-1:0] EMPTY_MARK = 16'hFFFF;
  localparam logic [VAL_W-1:0] DIST_LIMIT = 16'd1023;
  localparam logic [VAL_W-1:0] DIST_CLAMP = 16'd1022;

  localparam logic [KIND_W-1:0] KIND_CONVERT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_WRITE   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CLEAR   = 2'd2;

  localparam logic REG_INTERP = 1'b0;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [RAW_W-1:0]  raw_value;
    logic [EIDX_W-1:0] entry_index;
    logic [VAL_W-1:0]  entry_value;
  } in_beat_t;

  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic [NIDX_W-1:0] nearest_index;
    logic              table_empty;
  } out_beat_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_PICK,
    ST_NBR,
    ST_DIV,
    ST_ADJ,
    ST_DONE
  } state_t;

  function automatic logic [VAL_W-1:0] times_ten(input logic [VAL_W-1:0] x);
    return (x << 3) + (x << 1);
  endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/ctdc_if.sv -----
`default_nettype none
interface ctdc_in_if import ctdc_pkg::*; ();
  logic     valid;
  logic     ready;
  in_beat_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface ctdc_out_if import ctdc_pkg::*; ();
  logic      valid;
  logic      ready;
  out_beat_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/calibration_table_distance_converter.sv -----
// Calibration table distance converter.
// sample (valid/ready) carries one beat per command: write one table entry,
// clear the table, or convert a raw reading. Write and clear
// give no result. A conversion gives one beat on result (valid/ready).
// A conversion scans every entry through the table's single read port; when
// interpolating and a neighbour exists, it reads the neighbour entry and, if
// the gap is nonzero, runs the bit-serial divider and an adjust step; it then
// loads the output register. One item is in work at a time; sample.ready is
// high only while the block is idle.
// The result sits in an output register; a stalled receiver keeps it there
// and a finished conversion waits until the register frees up. A new
// command is taken while an earlier result still waits.
// Reset empties the table (per-entry valid bits, cleared together, so
// no clearing pass) and sets interpolate_enable to 1. The clear command
// empties the table the same way. APB register at byte 0: bit 0 is
// interpolate_enable.
`default_nettype none
module calibration_table_distance_converter import ctdc_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst,
  ctdc_in_if.sink                    sample,
  ctdc_out_if.source                 result,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [CFG_DATA_W-1:0] pwdata,
  output logic      [CFG_DATA_W-1:0] prdata,
  output logic                       pready
);

  logic interp;

  logic [VAL_W-1:0]       mem [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] vld;
  logic                   rd_en;
  logic [IDX_W-1:0]       rd_addr;
  logic [VAL_W-1:0]       rd_data;
  logic                   rd_vld;
  logic [VAL_W-1:0]       rd_entry;

  state_t state, state_next;

  logic [IDX_W-1:0]  cnt, pos;
  logic [VAL_W-1:0]  best, best_entry;
  logic              empty;
  logic [RAW_W-1:0]  raw;
  logic [VAL_W-1:0]  den, quo, rem, dst;
  logic [STEP_W-1:0] step;
  logic              ov;
  out_beat_t         obeat;

  logic              accept_in, is_conv;
  logic [VAL_W-1:0]  raw16, diff, pos_ten, den_c, num_c;
  logic              hit, up, at_last, at_first, need_nbr, div_last, out_free;
  logic [VAL_W:0]    trial;

  // config port
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      interp <= 1'b1;
    end else if (psel && penable && pwrite && paddr[CFG_ADDR_W-1] == REG_INTERP) begin
      interp <= pwdata[0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[CFG_ADDR_W-1] == REG_INTERP) begin
      prdata[0] = interp;
    end
  end

  // handshake
  assign accept_in = sample.valid && sample.ready;
  assign is_conv   = accept_in && sample.data.kind == KIND_CONVERT;
  assign out_free  = !ov || result.ready;

  // table memory
  always_ff @(posedge clk) begin
    if (accept_in && sample.data.kind == KIND_WRITE
        && int'(sample.data.entry_index) < TABLE_DEPTH) begin
      mem[IDX_W'(sample.data.entry_index)] <= sample.data.entry_value;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld    <= '0;
      rd_vld <= 1'b0;
    end else begin
      if (rd_en) begin
        rd_vld <= vld[rd_addr];
      end
      if (accept_in && sample.data.kind == KIND_CLEAR) begin
        vld <= '0;
      end else if (accept_in && sample.data.kind == KIND_WRITE
                   && int'(sample.data.entry_index) < TABLE_DEPTH) begin
        vld[IDX_W'(sample.data.entry_index)] <= 1'b1;
      end
    end
  end

  assign rd_entry = rd_vld ? rd_data : EMPTY_MARK;

  // datapath terms
  assign raw16    = VAL_W'(raw);
  assign diff     = (raw16 > rd_entry) ? raw16 - rd_entry : rd_entry - raw16;
  assign hit      = rd_entry != EMPTY_MARK && best > diff;
  assign up       = raw16 > best_entry;
  assign pos_ten  = times_ten(VAL_W'(pos));
  assign at_last  = pos == IDX_W'(TABLE_DEPTH - 1);
  assign at_first = pos == '0;
  assign need_nbr = interp && (up ? !at_last : !at_first);
  assign den_c    = up ? rd_entry - best_entry : best_entry - rd_entry;
  assign num_c    = times_ten(up ? raw16 - best_entry : best_entry - raw16);
  assign trial    = {rem, quo[VAL_W-1]} - {1'b0, den};
  assign div_last = step == STEP_W'(VAL_W - 1);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (is_conv) state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (cnt == IDX_W'(TABLE_DEPTH - 1)) state_next = ST_PICK;
      end
      ST_PICK: begin
        state_next = need_nbr ? ST_NBR : ST_DONE;
      end
      ST_NBR: begin
        state_next = (den_c == '0) ? ST_DONE : ST_DIV;
      end
      ST_DIV: begin
        if (div_last) state_next = ST_ADJ;
      end
      ST_ADJ: begin
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    sample.ready = 1'b0;
    rd_en        = 1'b0;
    rd_addr      = '0;
    case (state)
      ST_IDLE: begin
        sample.ready = 1'b1;
        rd_en        = is_conv;
      end
      ST_SCAN: begin
        rd_en   = 1'b1;
        rd_addr = cnt + 1'b1;
      end
      ST_PICK: begin
        rd_en   = need_nbr;
        rd_addr = up ? pos + 1'b1 : pos - 1'b1;
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      ov    <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_DONE && out_free) begin
        ov <= 1'b1;
      end else if (result.ready) begin
        ov <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (is_conv) begin
          cnt        <= '0;
          pos        <= '0;
          best       <= EMPTY_MARK;
          best_entry <= EMPTY_MARK;
          empty      <= 1'b1;
          raw        <= sample.data.raw_value;
        end
      end
      ST_SCAN: begin
        if (hit) begin
          best       <= diff;
          pos        <= cnt;
          best_entry <= rd_entry;
        end
        if (rd_entry != EMPTY_MARK) empty <= 1'b0;
        cnt <= cnt + 1'b1;
      end
      ST_PICK: begin
        dst <= (interp && up) ? pos_ten : VAL_W'(pos);
      end
      ST_NBR: begin
        dst  <= pos_ten;
        den  <= den_c;
        quo  <= num_c;
        rem  <= '0;
        step <= '0;
      end
      ST_DIV: begin
        if (!trial[VAL_W]) begin
          rem <= trial[VAL_W-1:0];
          quo <= {quo[VAL_W-2:0], 1'b1};
        end else begin
          rem <= {rem[VAL_W-2:0], quo[VAL_W-1]};
          quo <= {quo[VAL_W-2:0], 1'b0};
        end
        step <= step + 1'b1;
      end
      ST_ADJ: begin
        dst <= up ? pos_ten + quo : pos_ten - quo;
      end
      ST_DONE: begin
        if (out_free) begin
          obeat.distance      <= (dst > DIST_LIMIT) ? DIST_CLAMP[DIST_W-1:0]
                                                    : dst[DIST_W-1:0];
          obeat.nearest_index <= NIDX_W'(pos);
          obeat.table_empty   <= empty;
        end
      end
      default: begin
        cnt <= cnt;
      end
    endcase
  end

  assign result.valid = ov;
  assign result.data  = obeat;

endmodule
`default_nettype wire

// ----- tb/sv/testbench.sv -----
`default_nettype none
module testbench;
  import ctdc_pkg::*;

  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
  localparam logic [31:0] TENTHS = 32'd10;
  localparam int SETTLE_CYCLES = 200;
  localparam int LONG_HOLD_CYCLES = 600;

  logic clk = 1'b0;
  logic rst;
  logic psel, penable, pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic pready;

  ctdc_in_if  sample_if ();
  ctdc_out_if result_if ();

  calibration_table_distance_converter dut (
    .clk     (clk),
    .rst     (rst),
    .sample  (sample_if),
    .result  (result_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  logic [VAL_W-1:0] cal_table [TABLE_DEPTH];
  logic             interp_on;

  in_beat_t    pending_beats [$];
  out_beat_t   predicted_distances [$];
  int unsigned mismatches = 0;
  int unsigned send_gap, recv_stall;
  int unsigned send_idle_pct, recv_idle_pct;
  logic        hold_arm, hold_done;
  out_beat_t   want;

  function automatic in_beat_t beat(input logic [KIND_W-1:0] k, input logic [RAW_W-1:0] raw,
                                    input logic [EIDX_W-1:0] idx, input logic [VAL_W-1:0] val);
    in_beat_t b;
    b.kind = k;
    b.raw_value = raw;
    b.entry_index = idx;
    b.entry_value = val;
    return b;
  endfunction

  function automatic int unsigned draw_gap(input int unsigned pct);
    if ($urandom_range(1, 100) > pct) return 0;
    if ($urandom_range(0, 9) != 0) return $urandom_range(1, 3);
    return $urandom_range(20, 60);
  endfunction

  function automatic out_beat_t convert_reading(input logic [RAW_W-1:0] raw);
    logic [31:0] best, diff, num, den, dst, entry, rv;
    int unsigned pos;
    logic        none;
    out_beat_t   r;
    best = 32'hFFFF;
    pos = 0;
    none = 1'b1;
    rv = 32'(raw);
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (cal_table[i] != EMPTY_MARK) begin
        none = 1'b0;
        entry = 32'(cal_table[i]);
        diff = (rv > entry) ? rv - entry : entry - rv;
        if (best > diff) begin
          best = diff;
          pos = i;
        end
      end
    end
    dst = pos;
    if (interp_on) begin
      entry = 32'(cal_table[pos]);
      if (rv > entry) begin
        if (pos + 1 < TABLE_DEPTH) begin
          num = 32'(16'((rv - entry) * TENTHS));
          den = 32'(16'(32'(cal_table[pos + 1]) - entry));
          dst = (den != 0) ? 32'(16'(pos * TENTHS + num / den)) : 32'(16'(pos * TENTHS));
        end else begin
          dst = 32'(16'(pos * TENTHS));
        end
      end else if (pos >= 1) begin
        num = 32'(16'((entry - rv) * TENTHS));
        den = 32'(16'(entry - 32'(cal_table[pos - 1])));
        dst = (den != 0) ? 32'(16'(pos * TENTHS - num / den)) : 32'(16'(pos * TENTHS));
      end
    end
    if (dst > 32'(DIST_LIMIT)) dst = 32'(DIST_CLAMP);
    r.distance = dst[DIST_W-1:0];
    r.nearest_index = NIDX_W'(pos);
    r.table_empty = none;
    return r;
  endfunction

  task automatic absorb_command(input in_beat_t b);
    case (b.kind)
      KIND_CONVERT: predicted_distances.push_back(convert_reading(b.raw_value));
      KIND_WRITE: begin
        if (int'(b.entry_index) < TABLE_DEPTH) cal_table[b.entry_index] = b.entry_value;
      end
      KIND_CLEAR: begin
        foreach (cal_table[i]) cal_table[i] = EMPTY_MARK;
      end
      default: ;
    endcase
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      sample_if.valid <= 1'b0;
      send_gap <= 0;
    end else begin
      if (sample_if.valid && sample_if.ready) begin
        absorb_command(sample_if.data);
        void'(pending_beats.pop_front());
      end
      if (!sample_if.valid || sample_if.ready) begin
        if (send_gap != 0 || pending_beats.size() == 0) begin
          sample_if.valid <= 1'b0;
          if (send_gap != 0) send_gap <= send_gap - 1;
        end else begin
          sample_if.valid <= 1'b1;
          sample_if.data <= pending_beats[0];
          send_gap <= draw_gap(send_idle_pct);
        end
      end
    end
  end

  // receiver backpressure
  always @(posedge clk) begin
    if (rst) begin
      result_if.ready <= 1'b0;
      recv_stall <= 0;
      hold_done <= 1'b0;
    end else if (recv_stall != 0) begin
      result_if.ready <= 1'b0;
      recv_stall <= recv_stall - 1;
    end else if (hold_arm && !hold_done) begin
      result_if.ready <= 1'b0;
      recv_stall <= LONG_HOLD_CYCLES;
      hold_done <= 1'b1;
    end else begin
      int unsigned g;
      g = draw_gap(recv_idle_pct);
      result_if.ready <= (g == 0);
      recv_stall <= (g == 0) ? 0 : g - 1;
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst && result_if.valid && result_if.ready) begin
      if (predicted_distances.size() == 0) begin
        $error("result beat with nothing expected: %p", result_if.data);
        mismatches++;
      end else begin
        want = predicted_distances.pop_front();
        if (result_if.data.distance !== want.distance) begin
          $error("distance: expected %0d, got %0d", want.distance, result_if.data.distance);
          mismatches++;
        end
        if (result_if.data.nearest_index !== want.nearest_index) begin
          $error("nearest_index: expected %0d, got %0d", want.nearest_index,
                 result_if.data.nearest_index);
          mismatches++;
        end
        if (result_if.data.table_empty !== want.table_empty) begin
          $error("table_empty: expected %0d, got %0d", want.table_empty,
                 result_if.data.table_empty);
          mismatches++;
        end
      end
    end
  end

  task automatic write_interp(input logic en);
    logic [CFG_DATA_W-1:0] word;
    word = {31'($urandom), en};
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= CFG_ADDR_W'(REG_INTERP) << 2;
    pwdata <= word;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    interp_on = en;
  endtask

  task automatic drain();
    while (pending_beats.size() != 0 || predicted_distances.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // mostly well-formed ascending tables followed by nearby readings, plus noise
  task automatic queue_random(input int unsigned n);
    int unsigned count, k, stride, start, val, r;
    int          rr;
    logic [VAL_W-1:0] vals [$];
    count = 0;
    while (count < n) begin
      r = $urandom_range(0, 99);
      if (r < 60) begin
        k = $urandom_range(2, 8);
        stride = ($urandom_range(0, 3) == 0) ? 2 : 1;
        if ($urandom_range(0, 3) == 0) start = TABLE_DEPTH - 1 - (k - 1) * stride;
        else start = $urandom_range(0, TABLE_DEPTH - 1 - (k - 1) * stride);
        val = $urandom_range(0, 800);
        if ($urandom_range(0, 1) == 1) begin
          pending_beats.push_back(beat(KIND_CLEAR, RAW_W'($urandom), EIDX_W'($urandom),
                                       VAL_W'($urandom)));
          count++;
        end
        vals.delete();
        for (int j = 0; j < k; j++) begin
          pending_beats.push_back(beat(KIND_WRITE, RAW_W'($urandom),
                                       EIDX_W'(start + j * stride), VAL_W'(val)));
          vals.push_back(VAL_W'(val));
          count++;
          val += ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 60);
        end
        repeat ($urandom_range(2, 6)) begin
          if ($urandom_range(0, 4) == 0) rr = $urandom_range(0, 1023);
          else rr = int'(vals[$urandom_range(0, k - 1)]) + int'($urandom_range(0, 80)) - 40;
          if (rr < 0) rr = 0;
          if (rr > 1023) rr = 1023;
          pending_beats.push_back(beat(KIND_CONVERT, RAW_W'(rr), EIDX_W'($urandom),
                                       VAL_W'($urandom)));
          count++;
        end
      end else if (r < 80) begin
        pending_beats.push_back(beat(KIND_CONVERT, RAW_W'($urandom), EIDX_W'($urandom),
                                     VAL_W'($urandom)));
        count++;
      end else if (r < 90) begin
        case ($urandom_range(0, 3))
          0: val = EMPTY_MARK;
          1: val = $urandom_range(0, 65535);
          default: val = $urandom_range(0, 1100);
        endcase
        pending_beats.push_back(beat(KIND_WRITE, RAW_W'($urandom), EIDX_W'($urandom),
                                     VAL_W'(val)));
        count++;
      end else if (r < 95) begin
        pending_beats.push_back(beat(KIND_UNUSED, RAW_W'($urandom), EIDX_W'($urandom),
                                     VAL_W'($urandom)));
      end else begin
        pending_beats.push_back(beat(KIND_CLEAR, RAW_W'($urandom), EIDX_W'($urandom),
                                     VAL_W'($urandom)));
        count++;
      end
    end
  endtask

  initial begin
    rst = 1'b1;
    sample_if.valid = 1'b0;
    sample_if.data = '0;
    result_if.ready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    hold_arm = 1'b0;
    send_idle_pct = 20;
    recv_idle_pct = 20;
    foreach (cal_table[i]) cal_table[i] = EMPTY_MARK;
    interp_on = 1'b1;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // empty table, ignored kind, ties, zero gap, last entry, empty neighbor, clamp
    pending_beats.push_back(beat(KIND_CONVERT, 10'd0, 7'd0, 16'd0));
    pending_beats.push_back(beat(KIND_CONVERT, 10'd1023, 7'd127, 16'hFFFF));
    pending_beats.push_back(beat(KIND_UNUSED, 10'd1023, 7'd127, 16'd100));
    pending_beats.push_back(beat(KIND_WRITE, 10'd0, 7'd0, 16'd100));
    pending_beats.push_back(beat(KIND_WRITE, 10'd0, 7'd1, 16'd200));
    pending_beats.push_back(beat(KIND_WRITE, 10'd0, 7'd2, 16'd200));
    pending_beats.push_back(beat(KIND_CONVERT, 10'd150, 7'd0, 16'd0));
    pending_beats.push_back(beat(KIND_CONVERT, 10'd250, 7'd0, 16'd0));
    pending_beats.push_back(beat(KIND_CONVERT, 10'd50, 7'd0, 16'd0));
    pending_beats.push_back(beat(KIND_WRITE, 10'd0, 7'd127, 16'd1000));
    pending_beats.push_back(beat(KIND_CONVERT, 10'd1023, 7'd0, 16'd0));
    pending_beats.push_back(beat(KIND_CONVERT, 10'd990, 7'd0, 16'd0));
    pending_beats.push_back(beat(KIND_WRITE, 10'd0, 7'd2, EMPTY_MARK));
    pending_beats.push_back(beat(KIND_CONVERT, 10'd210, 7'd0, 16'd0));
    pending_beats.push_back(beat(KIND_WRITE, 10'd0, 7'd5, 16'd0));
    pending_beats.push_back(beat(KIND_CONVERT, 10'd0, 7'd0, 16'd0));
    pending_beats.push_back(beat(KIND_WRITE, 10'd0, 7'd64, 16'hFFFE));
    pending_beats.push_back(beat(KIND_CONVERT, 10'd1023, 7'd0, 16'd0));
    pending_beats.push_back(beat(KIND_CLEAR, 10'd0, 7'd0, 16'd0));
    pending_beats.push_back(beat(KIND_CONVERT, 10'd512, 7'd0, 16'd0));
    drain();

    write_interp(1'b1);
    send_idle_pct = 30;
    recv_idle_pct = 30;
    queue_random(150);
    while (pending_beats.size() > 110) @(posedge clk);
    hold_arm = 1'b1;
    drain();

    write_interp(1'b0);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    queue_random(150);
    drain();

    write_interp(1'b1);
    send_idle_pct = 60;
    recv_idle_pct = 60;
    queue_random(150);
    drain();

    if (mismatches == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

  initial begin
    #8000000;
    $display("FAILURE");
    $finish;
  end

endmodule
`default_nettype wire

// ----- filelist.f -----
hw/rtl/ctdc_pkg.sv
hw/rtl/ctdc_if.sv
hw/rtl/calibration_table_distance_converter.sv
tb/sv/testbench.sv
